[hw/rtl/tmcs_pkg.sv]
// shared types and constants for the terminal mux channel scanner
// item and result layouts, operation and function codes, back-end state type
// no dependencies
package tmcs_pkg;

    // default number of terminal lines
    localparam int DEF_MAX_LINES = 64;

    // stream widths in bits
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_LINES = 1'b0;
    localparam logic REG_UNIT  = 1'b1;
    localparam logic [6:0] LINES_RESET = 7'd64;
    localparam logic [2:0] UNIT_RESET  = 3'd0;

    // output word codes that send a character
    localparam logic [2:0] TX_CODE_A = 3'd4;
    localparam logic [2:0] TX_CODE_B = 3'd6;

    // lines examined per cycle during a connect search
    localparam int SEARCH_LANES = 8;

    // queue between front and back
    localparam int QDEPTH = 2;

    // raw action codes on the input stream
    typedef enum logic [2:0] {
        ACT_FUNC    = 3'd0,
        ACT_OUTPUT  = 3'd1,
        ACT_READ    = 3'd2,
        ACT_CONNECT = 3'd3,
        ACT_RECV    = 3'd4,
        ACT_DROP    = 3'd5
    } action_t;

    // classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_NONE,
        OP_FUNC,
        OP_OUT,
        OP_READ,
        OP_CONNECT,
        OP_RECV,
        OP_DROP
    } op_t;

    // selected channel function
    typedef enum logic [1:0] {
        FN_NONE   = 2'd0,
        FN_OUTPUT = 2'd1,
        FN_STATUS = 2'd2,
        FN_INPUT  = 2'd3
    } func_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH
    } st_t;

    // one queued item
    typedef struct packed {
        op_t         op;
        logic [11:0] word;
        logic [5:0]  line;
        logic [6:0]  rx;
    } item_t;

    // one result item, func_accepted in the lowest bit
    typedef struct packed {
        logic [5:0]  connect_line;
        logic        connect_ok;
        logic [6:0]  tx_char;
        logic [5:0]  tx_line;
        logic        tx_valid;
        logic [11:0] read_word;
        logic        read_valid;
        logic        func_accepted;
    } res_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic executing;
        logic searching;
    } back_stat_t;

endpackage

[hw/rtl/tmcs_front.sv]
// front end: accepts input items, classifies the action, queues them
// depends on tmcs_pkg
module tmcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action [2:0], channel_word [14:3], line_index [20:15], rx_char [27:21]
    input  logic [tmcs_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          q_valid,
    output tmcs_pkg::item_t               q_item,
    input  logic                          q_pop
);
    import tmcs_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    item_t            fifo_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    item_t            item_in;
    logic             push;

    // classify the incoming action
    always_comb
    begin
        item_in.word = s_tdata[14:3];
        item_in.line = s_tdata[20:15];
        item_in.rx   = s_tdata[27:21];
        unique case (s_tdata[2:0])
            ACT_FUNC:    item_in.op = OP_FUNC;
            ACT_OUTPUT:  item_in.op = OP_OUT;
            ACT_READ:    item_in.op = OP_READ;
            ACT_CONNECT: item_in.op = OP_CONNECT;
            ACT_RECV:    item_in.op = OP_RECV;
            ACT_DROP:    item_in.op = OP_DROP;
            default:     item_in.op = OP_NONE;
        endcase
    end

    // queue bookkeeping
    assign s_tready = (count_reg != CNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[hw/rtl/tmcs_back.sv]
// back end: line tables, scan counter, held characters, connect search
// and the result register; depends on tmcs_pkg
module tmcs_back #(
    parameter int MAX_LINES = tmcs_pkg::DEF_MAX_LINES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [6:0]                    lines_in_use,
    input  logic [2:0]                    unit_number,
    input  logic                          q_valid,
    input  tmcs_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tmcs_pkg::M_DATA_W-1:0] m_tdata,
    output tmcs_pkg::back_stat_t          stat
);
    import tmcs_pkg::*;

    localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int NCNT_W = $clog2(MAX_LINES + 1);
    localparam int NCHUNK = (MAX_LINES + SEARCH_LANES - 1) / SEARCH_LANES;
    localparam int PAD_W  = NCHUNK * SEARCH_LANES;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int LANE_W = $clog2(SEARCH_LANES);
    localparam int RES_W  = $bits(res_t);

    st_t                  state_reg, state_next;
    item_t                op_reg;
    func_t                func_reg, func_next;
    logic [7:0]           scan_reg, scan_next;
    logic [MAX_LINES-1:0] conn_reg, conn_next;
    logic [MAX_LINES-1:0] pend_reg, pend_next;
    logic [CH_W-1:0]      chunk_reg, chunk_next;
    logic                 out_valid_reg;
    res_t                 out_reg;
    res_t                 res;
    logic                 load_out;
    logic                 out_free;

    logic [6:0]           held_mem [MAX_LINES];
    logic [6:0]           mem_rdata_reg;
    logic                 mem_we;

    logic [NCNT_W-1:0]    n_lines;
    logic [LINE_W-1:0]    port_idx;
    logic [LINE_W-1:0]    ev_idx;
    logic                 port_ok;
    logic                 ev_in;
    logic [PAD_W-1:0]     conn_pad;
    logic [SEARCH_LANES-1:0] lane_free;
    logic                 hit;
    logic [LANE_W-1:0]    hit_lane;
    logic [8:0]           hit_pos;
    logic                 search_done;

    // effective number of lines
    assign n_lines = (32'(lines_in_use) > MAX_LINES) ? NCNT_W'(MAX_LINES)
                                                      : NCNT_W'(lines_in_use);

    assign out_free = !out_valid_reg || m_tready;
    assign port_idx = LINE_W'(scan_reg);
    assign ev_idx   = LINE_W'(op_reg.line);
    assign port_ok  = ({1'b0, scan_reg} < 9'(n_lines)) && conn_reg[port_idx];
    assign ev_in    = (9'(op_reg.line) < 9'(n_lines));

    // one chunk of lines per cycle for the lowest-free search
    assign conn_pad = PAD_W'(conn_reg);

    always_comb
    begin
        hit      = 1'b0;
        hit_lane = '0;
        for (int j = 0; j < SEARCH_LANES; j++)
        begin
            lane_free[j] = ((32'(chunk_reg) * SEARCH_LANES + j) < 32'(n_lines)) &&
                           !conn_pad[32'(chunk_reg) * SEARCH_LANES + j];
        end
        for (int j = SEARCH_LANES - 1; j >= 0; j--)
        begin
            if (lane_free[j])
            begin
                hit      = 1'b1;
                hit_lane = LANE_W'(j);
            end
        end
    end

    assign hit_pos     = 9'(32'(chunk_reg) * SEARCH_LANES + 32'(hit_lane));
    assign search_done = hit ||
                         ((32'(chunk_reg) + 1) * SEARCH_LANES >= 32'(n_lines));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (op_reg.op == OP_CONNECT) ? ST_SEARCH : ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop          = (state_reg == ST_IDLE) && q_valid && out_free;
        stat.executing = (state_reg == ST_EXEC);
        stat.searching = (state_reg == ST_SEARCH);
    end

    // execute the current item
    always_comb
    begin
        res        = '0;
        load_out   = 1'b0;
        func_next  = func_reg;
        scan_next  = scan_reg;
        conn_next  = conn_reg;
        pend_next  = pend_reg;
        chunk_next = chunk_reg;
        mem_we     = 1'b0;
        if (state_reg == ST_EXEC)
        begin
            load_out = (op_reg.op != OP_CONNECT);
            case (op_reg.op)
                OP_FUNC:
                begin
                    if (op_reg.word[11:9] == unit_number &&
                        op_reg.word[8:0] >= 9'(FN_OUTPUT) &&
                        op_reg.word[8:0] <= 9'(FN_INPUT))
                    begin
                        func_next         = func_t'(op_reg.word[1:0]);
                        scan_next         = '0;
                        res.func_accepted = 1'b1;
                    end
                end
                OP_OUT:
                begin
                    if (func_reg == FN_OUTPUT)
                    begin
                        scan_next = scan_reg + 8'd1;
                        if (port_ok && (op_reg.word[11:9] == TX_CODE_A ||
                                        op_reg.word[11:9] == TX_CODE_B))
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_line  = scan_reg[5:0];
                            res.tx_char  = op_reg.word[7:1];
                        end
                    end
                end
                OP_READ:
                begin
                    if (func_reg == FN_STATUS)
                    begin
                        res.read_valid = 1'b1;
                    end
                    else if (func_reg == FN_INPUT)
                    begin
                        scan_next      = scan_reg + 8'd1;
                        res.read_valid = 1'b1;
                        if (port_ok)
                        begin
                            res.read_word[9] = 1'b1;
                            if (pend_reg[port_idx])
                            begin
                                res.read_word[11]  = 1'b1;
                                res.read_word[7:1] = mem_rdata_reg;
                                pend_next[port_idx] = 1'b0;
                            end
                        end
                    end
                end
                OP_CONNECT:
                begin
                    chunk_next = '0;
                end
                OP_RECV:
                begin
                    if (ev_in && conn_reg[ev_idx] && !pend_reg[ev_idx] &&
                        op_reg.rx != 7'd0)
                    begin
                        mem_we            = 1'b1;
                        pend_next[ev_idx] = 1'b1;
                    end
                end
                OP_DROP:
                begin
                    if (32'(op_reg.line) < MAX_LINES)
                    begin
                        conn_next[ev_idx] = 1'b0;
                        pend_next[ev_idx] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_SEARCH)
        begin
            chunk_next = chunk_reg + 1'b1;
            load_out   = search_done;
            if (hit)
            begin
                conn_next[LINE_W'(hit_pos)] = 1'b1;
                pend_next[LINE_W'(hit_pos)] = 1'b0;
                res.connect_ok   = 1'b1;
                res.connect_line = hit_pos[5:0];
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= FN_NONE;
            scan_reg      <= '0;
            conn_reg      <= '0;
            pend_reg      <= '0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            scan_reg  <= scan_next;
            conn_reg  <= conn_next;
            pend_reg  <= pend_next;
            chunk_reg <= chunk_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_item;
        end
        if (load_out)
        begin
            out_reg <= res;
        end
    end

    // held character store, read address is the scanned line
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            held_mem[ev_idx] <= op_reg.rx;
        end
        mem_rdata_reg <= held_mem[port_idx];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - RES_W)'(0), out_reg};

endmodule

[hw/rtl/terminal_mux_channel_scanner.sv]
// Flow: an input item is queued in the front end, popped by the back end and then
// executed into the result register; a connect then searches for the lowest free
// line in groups of 8. The back end pops a new item only once the current one is
// done and the result register is free. Two items can queue while a result waits.
// Reset: rst_n clears function, scan counter, line flags, queue and result.
// Held characters are not cleared and are read only while pending.
module terminal_mux_channel_scanner #(
    parameter int MAX_LINES = tmcs_pkg::DEF_MAX_LINES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action [2:0], channel_word [14:3], line_index [20:15], rx_char [27:21]
    input  logic [tmcs_pkg::S_DATA_W-1:0]   s_tdata,
    // stream out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // func_accepted [0], read_valid [1], read_word [13:2], tx_valid [14],
    // tx_line [20:15], tx_char [27:21], connect_ok [28], connect_line [34:29]
    output logic [tmcs_pkg::M_DATA_W-1:0]   m_tdata,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tmcs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmcs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tmcs_pkg::*;

    logic [6:0] lines_reg;
    logic [2:0] unit_reg;
    logic       cfg_write;
    logic       q_valid;
    logic       q_pop;
    item_t      q_item;
    back_stat_t stat;

    // register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_reg <= LINES_RESET;
            unit_reg  <= UNIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_LINES: lines_reg <= pwdata[6:0];
                REG_UNIT:  unit_reg  <= pwdata[2:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LINES: prdata = APB_DATA_W'(lines_reg);
            REG_UNIT:  prdata = APB_DATA_W'(unit_reg);
            default:   prdata = '0;
        endcase
    end

    // front end and queue
    tmcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back end
    tmcs_back #(
        .MAX_LINES (MAX_LINES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .lines_in_use (lines_reg),
        .unit_number  (unit_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .stat         (stat)
    );

`ifndef NO_ASSERTIONS
    // at most one kind of result per item
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({m_tdata[0], m_tdata[1], m_tdata[14], m_tdata[28]}))
        else $error("result carries more than one kind");

    // a ready character is only reported on a connected line
    a_ready_conn: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[13]) |-> m_tdata[11])
        else $error("char ready without connected bit");

    // a failed connect reports line zero
    a_conn_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[28]) |-> (m_tdata[34:29] == 6'd0))
        else $error("connect line set without connect");

    // the result register is empty while an item is being worked on
    a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.executing || stat.searching) |-> !m_tvalid)
        else $error("result pending while back end busy");
`endif

endmodule

[bench/terminal_mux_channel_scanner_tb.sv]
// self-checking bench for the terminal mux channel scanner
// directed table then random traffic, each result checked against its table entry or a local scanner model
// depends on tmcs_pkg and terminal_mux_channel_scanner
module terminal_mux_channel_scanner_tb;
    import tmcs_pkg::*;

    localparam int LINE_SLOTS     = DEF_MAX_LINES;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 250;
    localparam int PHASE_ITEMS    = 300;
    localparam int NUM_PHASES     = 6;

    // action codes the block treats as no-ops
    localparam logic [2:0] ACT_UNDEF_A = 3'd6;
    localparam logic [2:0] ACT_UNDEF_B = 3'd7;

    // one input item, action in the lowest bits
    typedef struct packed {
        logic [6:0]  rx;
        logic [5:0]  line;
        logic [11:0] word;
        logic [2:0]  act;
    } scan_item_t;

    // one row of the directed table
    typedef struct {
        scan_item_t it;
        bit         typed;
        res_t       want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // action [2:0], channel_word [14:3], line_index [20:15], rx_char [27:21]
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // func_accepted [0], read_valid [1], read_word [13:2], tx_valid [14],
    // tx_line [20:15], tx_char [27:21], connect_ok [28], connect_line [34:29]
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // scanner model state
    logic [6:0]  lines_cfg;
    logic [2:0]  unit_cfg;
    func_t       cur_fn;
    logic [7:0]  scan_ptr;
    logic        conn_flag [LINE_SLOTS];
    logic        rx_pending [LINE_SLOTS];
    logic [6:0]  rx_hold [LINE_SLOTS];

    res_t        result_q [$];
    dir_row_t    dir_rows [$];
    int          err_count;
    int          idle_cycles;
    bit          calm;
    bit          quiet;
    bit          long_hold;

    terminal_mux_channel_scanner uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // function word carrying a unit number and a function code
    function automatic logic [11:0] fn_word(logic [2:0] unit, func_t f);
        return {unit, 7'd0, f};
    endfunction

    // advance the scanner model by one item and return its result
    function automatic res_t scanner_step(scan_item_t it);
        res_t        r;
        int          n;
        logic [7:0]  port;
        logic [11:0] rd;
        r = '0;
        n = (lines_cfg > LINE_SLOTS) ? LINE_SLOTS : int'(lines_cfg);
        case (it.act)
            ACT_FUNC:
            begin
                if (it.word[11:9] == unit_cfg && it.word[8:0] >= 9'd1 && it.word[8:0] <= 9'd3)
                begin
                    cur_fn          = func_t'(it.word[1:0]);
                    scan_ptr        = '0;
                    r.func_accepted = 1'b1;
                end
            end
            ACT_OUTPUT:
            begin
                if (cur_fn == FN_OUTPUT)
                begin
                    port     = scan_ptr;
                    scan_ptr = scan_ptr + 8'd1;
                    if (port < n)
                    begin
                        if (conn_flag[port[5:0]] &&
                            (it.word[11:9] == TX_CODE_A || it.word[11:9] == TX_CODE_B))
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_line  = port[5:0];
                            r.tx_char  = it.word[7:1];
                        end
                    end
                end
            end
            ACT_READ:
            begin
                if (cur_fn == FN_STATUS)
                begin
                    r.read_valid = 1'b1;
                end
                else if (cur_fn == FN_INPUT)
                begin
                    rd       = '0;
                    port     = scan_ptr;
                    scan_ptr = scan_ptr + 8'd1;
                    if (port < n)
                    begin
                        if (conn_flag[port[5:0]])
                        begin
                            rd[9] = 1'b1;
                            if (rx_pending[port[5:0]])
                            begin
                                rd[11]                 = 1'b1;
                                rd[7:1]                = rx_hold[port[5:0]];
                                rx_pending[port[5:0]]  = 1'b0;
                            end
                        end
                    end
                    r.read_valid = 1'b1;
                    r.read_word  = rd;
                end
            end
            ACT_CONNECT:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (!conn_flag[i])
                    begin
                        conn_flag[i]   = 1'b1;
                        rx_pending[i]  = 1'b0;
                        r.connect_ok   = 1'b1;
                        r.connect_line = 6'(i);
                        break;
                    end
                end
            end
            ACT_RECV:
            begin
                if (it.line < n && conn_flag[it.line] && !rx_pending[it.line] && it.rx != '0)
                begin
                    rx_hold[it.line]    = it.rx;
                    rx_pending[it.line] = 1'b1;
                end
            end
            ACT_DROP:
            begin
                conn_flag[it.line]  = 1'b0;
                rx_pending[it.line] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // random item, mostly well-formed for the current unit
    function automatic scan_item_t random_item();
        scan_item_t it;
        int         pick;
        it.act  = ACT_READ;
        it.word = 12'($urandom);
        it.line = 6'($urandom);
        it.rx   = 7'($urandom);
        pick    = $urandom_range(0, 99);
        if (pick < 7)
        begin
            it.act = ACT_FUNC;
            if ($urandom_range(0, 3) != 0)
                it.word = fn_word(unit_cfg, func_t'($urandom_range(1, 3)));
        end
        else if (pick < 30)
        begin
            it.act = ACT_OUTPUT;
            if ($urandom_range(0, 3) != 0)
                it.word[11:9] = $urandom_range(0, 1) ? TX_CODE_A : TX_CODE_B;
        end
        else if (pick < 52)
        begin
            it.act = ACT_READ;
        end
        else if (pick < 66)
        begin
            it.act = ACT_CONNECT;
        end
        else if (pick < 84)
        begin
            it.act = ACT_RECV;
            if ($urandom_range(0, 1) != 0)
                it.line = 6'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0)
                it.rx = '0;
        end
        else if (pick < 96)
        begin
            it.act = ACT_DROP;
            if ($urandom_range(0, 1) != 0)
                it.line = 6'($urandom_range(0, 7));
        end
        else
        begin
            it.act = $urandom_range(0, 1) ? ACT_UNDEF_A : ACT_UNDEF_B;
        end
        return it;
    endfunction

    function automatic void check_field(string fname, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want_v, got_v);
            err_count++;
        end
    endfunction

    task automatic add_row(logic [2:0] act, logic [11:0] word, logic [5:0] line,
                           logic [6:0] rx, bit typed, res_t want);
        dir_row_t row;
        row.it.act  = act;
        row.it.word = word;
        row.it.line = line;
        row.it.rx   = rx;
        row.typed   = typed;
        row.want    = want;
        dir_rows.push_back(row);
    endtask

    // offer one item, with an optional gap first, and log its expected result
    task automatic send_item(scan_item_t it, bit typed, res_t want);
        res_t predicted;
        if (!calm && !quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - $bits(scan_item_t)){1'b0}}, it};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = scanner_step(it);
        result_q.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait until the block has drained
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_reg(logic reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_LINES)
            lines_cfg = value[6:0];
        else
            unit_cfg = value[2:0];
        @(posedge clk);
    endtask

    // receiver: random stalls, one long hold on request, steady at the end
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (result_q.size() == 0)
            begin
                $display("%0t: result expected none, got 0x%0h", $time, got);
                err_count++;
            end
            else
            begin
                want = result_q.pop_front();
                check_field("func_accepted", want.func_accepted, got.func_accepted);
                check_field("read_valid", want.read_valid, got.read_valid);
                check_field("read_word", want.read_word, got.read_word);
                check_field("tx_valid", want.tx_valid, got.tx_valid);
                check_field("tx_line", want.tx_line, got.tx_line);
                check_field("tx_char", want.tx_char, got.tx_char);
                check_field("connect_ok", want.connect_ok, got.connect_ok);
                check_field("connect_line", want.connect_line, got.connect_line);
            end
        end
    end

    // watchdog on cycles with no handshake on any port
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        res_t  want_none;
        res_t  want_func;
        res_t  want_status;
        res_t  want_conn0;
        int    lines_plan [NUM_PHASES];
        int    unit_plan [NUM_PHASES];
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        err_count   = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        quiet       = 1'b0;
        long_hold   = 1'b0;
        lines_cfg   = LINES_RESET;
        unit_cfg    = UNIT_RESET;
        cur_fn      = FN_NONE;
        scan_ptr    = '0;
        for (int i = 0; i < LINE_SLOTS; i++)
        begin
            conn_flag[i]  = 1'b0;
            rx_pending[i] = 1'b0;
            rx_hold[i]    = '0;
        end
        lines_plan = '{1, 0, 127, 8, 64, 0};
        unit_plan  = '{7, 3, 5, 2, 0, 0};

        want_none   = '0;
        want_func   = '0;
        want_func.func_accepted = 1'b1;
        want_status = '0;
        want_status.read_valid  = 1'b1;
        want_conn0  = '0;
        want_conn0.connect_ok   = 1'b1;

        // directed table: no function, line events, declined and accepted functions,
        // status, input and output modes, drops and undefined actions
        add_row(ACT_READ,    12'o0000, 6'd0,  7'h00, 1'b1, want_none);
        add_row(ACT_OUTPUT,  12'o4376, 6'd0,  7'h00, 1'b1, want_none);
        add_row(ACT_CONNECT, 12'o0000, 6'd0,  7'h00, 1'b1, want_conn0);
        add_row(ACT_CONNECT, 12'o7777, 6'd63, 7'h7f, 1'b0, want_none);
        add_row(ACT_RECV,    12'o0000, 6'd0,  7'h7f, 1'b1, want_none);
        add_row(ACT_RECV,    12'o0000, 6'd0,  7'h55, 1'b1, want_none);
        add_row(ACT_RECV,    12'o0000, 6'd1,  7'h00, 1'b1, want_none);
        add_row(ACT_RECV,    12'o7777, 6'd63, 7'h2a, 1'b1, want_none);
        add_row(ACT_FUNC,    12'o0004, 6'd0,  7'h00, 1'b1, want_none);
        add_row(ACT_FUNC, fn_word(3'd1, FN_INPUT), 6'd0, 7'h00, 1'b1, want_none);
        add_row(ACT_FUNC,    12'o7777, 6'd0,  7'h00, 1'b1, want_none);
        add_row(ACT_FUNC, fn_word(3'd0, FN_INPUT), 6'd0, 7'h00, 1'b1, want_func);
        add_row(ACT_READ,    12'o0000, 6'd0,  7'h00, 1'b0, want_none);
        add_row(ACT_READ,    12'o7777, 6'd0,  7'h00, 1'b0, want_none);
        add_row(ACT_READ,    12'o0000, 6'd0,  7'h00, 1'b0, want_none);
        add_row(ACT_FUNC, fn_word(3'd0, FN_STATUS), 6'd0, 7'h00, 1'b1, want_func);
        add_row(ACT_READ,    12'o0000, 6'd0,  7'h00, 1'b1, want_status);
        add_row(ACT_OUTPUT,  12'o4000, 6'd0,  7'h00, 1'b1, want_none);
        add_row(ACT_FUNC, fn_word(3'd0, FN_OUTPUT), 6'd0, 7'h00, 1'b1, want_func);
        add_row(ACT_OUTPUT,  12'o7777, 6'd0,  7'h00, 1'b0, want_none);
        add_row(ACT_OUTPUT,  12'o4376, 6'd0,  7'h00, 1'b0, want_none);
        add_row(ACT_OUTPUT,  12'o6000, 6'd0,  7'h00, 1'b0, want_none);
        add_row(ACT_DROP,    12'o0000, 6'd0,  7'h00, 1'b1, want_none);
        add_row(ACT_DROP,    12'o7777, 6'd63, 7'h7f, 1'b1, want_none);
        add_row(ACT_UNDEF_A, 12'o0000, 6'd0,  7'h00, 1'b1, want_none);
        add_row(ACT_UNDEF_B, 12'o7777, 6'd63, 7'h7f, 1'b1, want_none);

        // reset once
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
        settle_block();

        // random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            calm = (p == NUM_PHASES - 1);
            if (p == NUM_PHASES - 1)
            begin
                lines_plan[p] = $urandom_range(1, 64);
                unit_plan[p]  = $urandom_range(0, 7);
            end
            write_reg(REG_LINES, 32'(lines_plan[p]));
            write_reg(REG_UNIT, 32'(unit_plan[p]));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 64 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                // long receiver hold so the block backs up into the input
                if (p == 2 && k == 100)
                    long_hold = 1'b1;
                // sender pause until the block is empty
                if (p == 3 && k == 150)
                    settle_block();
                send_item(random_item(), 1'b0, want_none);
            end
            settle_block();
        end

        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[terminal_mux_channel_scanner.f]
hw/rtl/tmcs_pkg.sv
hw/rtl/tmcs_front.sv
hw/rtl/tmcs_back.sv
hw/rtl/terminal_mux_channel_scanner.sv
bench/terminal_mux_channel_scanner_tb.sv
